### hdl/ffga_pkg.sv
`timescale 1ns / 1ps

package ffga_pkg;

    localparam int GATES       = 16;
    localparam int TIME_WIDTH  = 32;
    localparam int CFG_W       = 5;
    localparam int GATE_IDX_W  = 4;
    localparam int SERVED_W    = 16;
    localparam int CFG_RESET   = 16;

    // Address width into the gate table, and a counter width that can also hold GATES.
    localparam int IDX_W   = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int LIMIT_W = $clog2(GATES + 1);

    localparam logic [SERVED_W-1:0] SERVED_MAX = {SERVED_W{1'b1}};

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
    } tbl_cmd_t;

    typedef struct packed {
        logic                  granted;
        logic [GATE_IDX_W-1:0] gate_index;
        logic [SERVED_W-1:0]   served_count;
    } result_t;

endpackage

### hdl/first_fit_gate_allocator.sv
`timescale 1ns / 1ps

// First-fit gate allocator.
// Requests enter on the s_ channel (valid/ready) with an arrival time, a departure
// time and a first-of-run flag; one result per request leaves on the m_ channel
// (valid/ready): granted, the gate index (zero when refused) and the served count.
// The gates_in_use register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, and the block itself does not enforce this. It resets
// to 16, and zero refuses every request. Once a request is taken, a single
// comparator walks the gates one per cycle from gate 0 and stops at the first gate
// whose release time is below the arrival time. s_ready is low for the whole scan
// and comes back in the cycle after it, so a new request cannot be taken before
// the last one's scan is done.
// The result sits in an output register, so a new request can be taken while it
// waits; if the receiver holds m_ready low, the next scan finishes and waits for
// the register, keeping s_ready low.
// Reset (aresetn, synchronous, active low) releases all gates at time zero, clears
// the served count and restores gates_in_use to 16. A first-of-run request does
// the same clear, minus the register, before it is served.
module first_fit_gate_allocator
    import ffga_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_WIDTH-1:0] s_arrival_time,
    input  logic [TIME_WIDTH-1:0] s_departure_time,
    input  logic                  s_first_of_run,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_granted,
    output logic [GATE_IDX_W-1:0] m_gate_index,
    output logic [SERVED_W-1:0]   m_served_count
);

    logic [CFG_W-1:0]      gates_in_use_reg;
    logic                  m_valid_reg;
    result_t               result_reg;
    logic                  out_free;
    logic                  res_load;
    result_t               res;
    tbl_cmd_t              tbl_cmd;
    logic [TIME_WIDTH-1:0] tbl_wr_data;
    logic [TIME_WIDTH-1:0] tbl_rd_data;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gates_in_use_reg <= CFG_W'(CFG_RESET);
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                gates_in_use_reg <= cfg_wdata;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            result_reg <= res;
        end
    end

    ffga_scan_unit u_scan (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .gates_in_use     (gates_in_use_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_arrival_time   (s_arrival_time),
        .s_departure_time (s_departure_time),
        .s_first_of_run   (s_first_of_run),
        .out_free         (out_free),
        .res_load         (res_load),
        .res              (res),
        .tbl_cmd          (tbl_cmd),
        .tbl_wr_data      (tbl_wr_data),
        .tbl_rd_data      (tbl_rd_data)
    );

    ffga_gate_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (tbl_cmd),
        .wr_data (tbl_wr_data),
        .rd_data (tbl_rd_data)
    );

    assign m_valid        = m_valid_reg;
    assign m_granted      = result_reg.granted;
    assign m_gate_index   = result_reg.gate_index;
    assign m_served_count = result_reg.served_count;

endmodule

### hdl/ffga_gate_table.sv
`timescale 1ns / 1ps

module ffga_gate_table
    import ffga_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tbl_cmd_t              cmd,
    input  logic [TIME_WIDTH-1:0] wr_data,
    output logic [TIME_WIDTH-1:0] rd_data
);

    logic [GATES-1:0]      valid_reg;
    logic [GATES-1:0]      valid_next;
    logic [TIME_WIDTH-1:0] release_reg [GATES];

    // A gate whose valid bit is low has been released at time zero.
    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear) begin
            valid_next = '0;
        end else if (cmd.wr_en) begin
            valid_next[cmd.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            release_reg[cmd.addr] <= wr_data;
        end
    end

    assign rd_data = valid_reg[cmd.addr] ? release_reg[cmd.addr] : '0;

endmodule

### hdl/ffga_scan_unit.sv
`timescale 1ns / 1ps

module ffga_scan_unit
    import ffga_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CFG_W-1:0]      gates_in_use,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_WIDTH-1:0] s_arrival_time,
    input  logic [TIME_WIDTH-1:0] s_departure_time,
    input  logic                  s_first_of_run,
    input  logic                  out_free,
    output logic                  res_load,
    output result_t               res,
    output tbl_cmd_t              tbl_cmd,
    output logic [TIME_WIDTH-1:0] tbl_wr_data,
    input  logic [TIME_WIDTH-1:0] tbl_rd_data
);

    scan_state_t           state_reg, state_next;
    logic [LIMIT_W-1:0]    idx_reg, idx_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [TIME_WIDTH-1:0] arrive_reg, arrive_next;
    logic [TIME_WIDTH-1:0] depart_reg, depart_next;
    logic [SERVED_W-1:0]   served_reg, served_next;

    logic                accept;
    logic                in_range;
    logic                hit;
    logic                done;
    logic                commit;
    logic [SERVED_W-1:0] served_after;

    assign accept   = s_valid && s_ready;
    assign in_range = idx_reg < limit_reg;
    // The one comparator: the gate under the scan pointer against the arrival time.
    assign hit      = in_range && (tbl_rd_data < arrive_reg);
    assign done     = (state_reg == ST_SCAN) && (hit || !in_range);
    // A finished scan waits here until the output register can take its result.
    assign commit   = done && out_free;

    assign served_after = (hit && (served_reg != SERVED_MAX)) ? served_reg + 1'b1 : served_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        res_load         = 1'b0;
        tbl_cmd.clear    = 1'b0;
        tbl_cmd.wr_en    = 1'b0;
        tbl_cmd.addr     = idx_reg[IDX_W-1:0];
        tbl_wr_data      = depart_reg;
        res.granted      = hit;
        res.gate_index   = hit ? GATE_IDX_W'(idx_reg) : '0;
        res.served_count = served_after;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                tbl_cmd.clear = s_valid && s_first_of_run;
            end
            ST_SCAN: begin
                res_load      = commit;
                tbl_cmd.wr_en = commit && hit;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        idx_next    = idx_reg;
        limit_next  = limit_reg;
        arrive_next = arrive_reg;
        depart_next = depart_reg;
        served_next = served_reg;
        if (accept) begin
            idx_next    = '0;
            arrive_next = s_arrival_time;
            depart_next = s_departure_time;
            if (32'(gates_in_use) > 32'(GATES)) begin
                limit_next = LIMIT_W'(GATES);
            end else begin
                limit_next = LIMIT_W'(gates_in_use);
            end
            if (s_first_of_run) begin
                served_next = '0;
            end
        end else if (commit) begin
            served_next = served_after;
        end else if ((state_reg == ST_SCAN) && !done) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            served_reg <= '0;
        end else begin
            state_reg  <= state_next;
            served_reg <= served_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        limit_reg  <= limit_next;
        arrive_reg <= arrive_next;
        depart_reg <= depart_next;
    end

endmodule

### hdl/ffga_checker.sv
`timescale 1ns / 1ps

module ffga_checker
    import ffga_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_granted,
    input logic [GATE_IDX_W-1:0] m_gate_index,
    input logic [SERVED_W-1:0]   m_served_count
);

    // A refused request never names a gate.
    a_refused_index_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> m_gate_index == '0
    ) else $error("refused transaction carries a nonzero gate index");

    // The block takes one transaction at a time: a scan follows every acceptance.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready
    ) else $error("input accepted again right after an acceptance");

    // A new result only appears at the end of a scan, while the input side is busy.
    a_result_after_scan: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready)
    ) else $error("result appeared without a scan in progress");

    a_output_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted) && $stable(m_gate_index)
                                 && $stable(m_served_count)
    ) else $error("stalled result changed");

endmodule

bind first_fit_gate_allocator ffga_checker u_ffga_checker (.*);

### test/tb_first_fit_gate_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_gate_allocator;
    import ffga_pkg::*;

    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int PHASE_ITEMS      = 170;
    localparam int SINGLE_GATE_RUNS = 40;
    localparam int PHASES           = 9;

    typedef struct {
        logic [TIME_WIDTH-1:0] arrival;
        logic [TIME_WIDTH-1:0] departure;
        logic                  first;
        bit                    typed;
        result_t               want;
    } probe_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [TIME_WIDTH-1:0] s_arrival_time;
    logic [TIME_WIDTH-1:0] s_departure_time;
    logic                  s_first_of_run;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_granted;
    logic [GATE_IDX_W-1:0] m_gate_index;
    logic [SERVED_W-1:0]   m_served_count;

    // Predictor state: release time per gate, served counter and the gate count register.
    logic [TIME_WIDTH-1:0] release_at [GATES];
    logic [SERVED_W-1:0]   granted_total;
    logic [CFG_W-1:0]      gate_limit;

    result_t               pending_results [$];
    result_t               head_result;
    int                    fail_count = 0;
    int                    cycle_count = 0;
    logic [TIME_WIDTH-1:0] clock_now = '0;
    int unsigned           step_max = 8;
    int unsigned           hold_max = 100;
    bit                    tx_idling = 1'b0;
    bit                    rx_idling = 1'b0;
    int                    stall_left = 0;

    // Gates fill one by one, then a refusal; rows with typed results are the obvious ones.
    probe_row_t probe_rows [25] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd0}},
        '{32'h0000_0001, 32'h0000_000A, 1'b0, 1'b1, '{1'b1, 4'd0, 16'd1}},
        '{32'h0000_0005, 32'h0000_0014, 1'b0, 1'b1, '{1'b1, 4'd1, 16'd2}},
        '{32'h0000_000A, 32'h0000_001E, 1'b0, 1'b0, '0},
        '{32'h0000_000B, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 4'd0, 16'd1}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b1, 4'd15, 16'd16}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, '{1'b0, 4'd0, 16'd16}},
        '{32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 4'd0, 16'd1}},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, '0}
    };

    first_fit_gate_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_arrival_time   (s_arrival_time),
        .s_departure_time (s_departure_time),
        .s_first_of_run   (s_first_of_run),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted        (m_granted),
        .m_gate_index     (m_gate_index),
        .m_served_count   (m_served_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic result_t allocate_gate(input logic [TIME_WIDTH-1:0] arrival,
                                              input logic [TIME_WIDTH-1:0] departure,
                                              input logic first);
        result_t outcome;
        int      limit;
        int      pick;
        if (first) begin
            foreach (release_at[g]) release_at[g] = '0;
            granted_total = '0;
        end
        limit = (gate_limit > GATES) ? GATES : int'(gate_limit);
        pick = -1;
        for (int g = 0; g < limit; g++) begin
            if (pick < 0 && release_at[g] < arrival) pick = g;
        end
        outcome = '0;
        if (pick >= 0) begin
            release_at[pick] = departure;
            if (granted_total != SERVED_MAX) granted_total = granted_total + 1'b1;
            outcome.granted    = 1'b1;
            outcome.gate_index = GATE_IDX_W'(pick);
        end
        outcome.served_count = granted_total;
        return outcome;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (fail_count < 32)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending", 32'(m_served_count), 0);
            end else begin
                head_result = pending_results.pop_front();
                if (m_granted !== head_result.granted)
                    note_mismatch("granted", 32'(m_granted), 32'(head_result.granted));
                if (m_gate_index !== head_result.gate_index)
                    note_mismatch("gate_index", 32'(m_gate_index),
                                  32'(head_result.gate_index));
                if (m_served_count !== head_result.served_count)
                    note_mismatch("served_count", 32'(m_served_count),
                                  32'(head_result.served_count));
            end
        end
    end

    // Receiver: stalls come in random bursts while enabled.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [TIME_WIDTH-1:0] arrival,
                                input logic [TIME_WIDTH-1:0] departure,
                                input logic first, input bit typed, input result_t want);
        result_t predicted;
        @(negedge aclk);
        s_valid          <= 1'b1;
        s_arrival_time   <= arrival;
        s_departure_time <= departure;
        s_first_of_run   <= first;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = allocate_gate(arrival, departure, first);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic pause_requests(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_gate_count(input logic [CFG_W-1:0] count);
        wait_for_drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        gate_limit = count;
    endtask

    // Mostly sorted requests with overlapping stays, plus some unsorted noise.
    task automatic random_request(input bit new_run);
        logic [TIME_WIDTH-1:0] arrival;
        logic [TIME_WIDTH-1:0] departure;
        logic                  first;
        int unsigned           kind;
        kind  = $urandom_range(0, 99);
        first = new_run || (kind < 3);
        if (first)
            clock_now = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 64);
        if (kind < 90) begin
            clock_now = clock_now + $urandom_range(0, step_max);
            arrival   = clock_now;
            departure = arrival + $urandom_range(0, hold_max);
        end else begin
            arrival   = $urandom();
            departure = $urandom();
        end
        send_request(arrival, departure, first, 1'b0, '0);
        if (tx_idling && $urandom_range(0, 5) == 0) pause_requests($urandom_range(1, 16));
    endtask

    initial begin
        int unsigned phase_gates [PHASES];
        logic [CFG_W-1:0] count;

        phase_gates      = '{0, 1, 31, 16, 7, 17, 2, 0, 16};
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_arrival_time   = '0;
        s_departure_time = '0;
        s_first_of_run   = 1'b0;
        foreach (release_at[g]) release_at[g] = '0;
        granted_total = '0;
        gate_limit    = CFG_W'(CFG_RESET);
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows run on the gate count left by reset.
        foreach (probe_rows[i])
            send_request(probe_rows[i].arrival, probe_rows[i].departure, probe_rows[i].first,
                         probe_rows[i].typed, probe_rows[i].want);

        for (int p = 0; p < PHASES; p++) begin
            count = (p == 7) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(phase_gates[p]);
            set_gate_count(count);
            step_max  = $urandom_range(1, 40);
            hold_max  = step_max * $urandom_range(1, 30);
            tx_idling = (p % 3) != 1;
            rx_idling = (p % 4) != 2;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through, hold the sender until the block has emptied.
                if (n == PHASE_ITEMS / 2) wait_for_drain();
                random_request(n == 0);
            end
        end

        // Single gate, always free, with no idling on either side.
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        set_gate_count(CFG_W'(1));
        for (int n = 0; n < SINGLE_GATE_RUNS; n++)
            send_request($urandom_range(32'h8000_0000, 32'hFFFF_FFFF),
                         $urandom_range(0, 32'h7FFF_FFFF), n == 0, 1'b0, '0);

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch("results never delivered", pending_results.size(), 0);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ffga_pkg.sv
hdl/ffga_gate_table.sv
hdl/ffga_scan_unit.sv
hdl/first_fit_gate_allocator.sv
hdl/ffga_checker.sv
test/tb_first_fit_gate_allocator.sv
